### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define AST_SAME(lbl, clk, rstn, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);

// implication checked in the next cycle
`define AST_NEXT(lbl, clk, rstn, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);

`endif

### rtl/core/htd_pkg.sv
package htd_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int MAX_RESULTS = 8;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_DATA = 1'b1
    } t_mode;

    typedef enum logic {
        REG_MSG_LEN   = 1'b0,
        REG_ENTRY_CNT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic        mode;
        logic [7:0]  entry_index;
        logic [7:0]  entry_symbol;
        logic [5:0]  entry_length;
        logic [31:0] entry_code;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] symbol;
        logic       done_res;
        logic       error;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  symbol;
        logic [5:0]  length;
        logic [31:0] code;
    } t_entry;

endpackage

### rtl/core/huffman_table_decoder.sv
// a table load writes its entry as it leaves the queue; a byte starts a longest-code scan
// over N = min(entry_count, TABLE_DEPTH) entries, then a match scan of those entries per symbol
// items are handled one at a time, with the table memory read one entry at a time; a 2-deep
// request queue lets new requests arrive while a byte is being decoded
// reset: synchronous active low, clears control state, message_length 0, entry_count 1
module huffman_table_decoder
    import htd_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32,
    parameter int TABLE_DEPTH  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] r_msg_len;
    logic [8:0]  r_entry_cnt;
    logic        wr_en;
    t_reg_idx    reg_sel;
    logic        q_valid;
    t_in_item    q_data;
    logic        q_pop;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        unique case (reg_sel)
            REG_MSG_LEN:   prdata = r_msg_len;
            REG_ENTRY_CNT: prdata = {23'd0, r_entry_cnt};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_len   <= 32'd0;
            r_entry_cnt <= 9'd1;
        end else if (wr_en) begin
            if (reg_sel == REG_MSG_LEN) begin
                r_msg_len <= pwdata;
            end else begin
                r_entry_cnt <= pwdata[8:0];
            end
        end
    end

    htd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .o_q_data   (q_data),
        .i_q_pop    (q_pop)
    );

    htd_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .TABLE_DEPTH  (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .i_restart   (wr_en && reg_sel == REG_MSG_LEN),
        .i_msg_len   (r_msg_len),
        .i_entry_cnt (r_entry_cnt),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/core/htd_front.sv
module htd_front
    import htd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    output logic     o_q_valid,
    output t_in_item o_q_data,
    input  logic     i_q_pop
);

    t_in_item   r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       n_wr;
    logic       n_rd;
    logic [1:0] n_cnt;
    logic       push;
    logic       pop;

    assign o_in_ready = (r_cnt != 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_data   = r_slot[r_rd];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_q_pop && o_q_valid;

    always_comb begin
        n_wr  = push ? ~r_wr : r_wr;
        n_rd  = pop ? ~r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= i_in_data;
        end
    end

endmodule

### rtl/core/htd_back.sv
module htd_back
    import htd_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32,
    parameter int TABLE_DEPTH  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_in_item    i_q_data,
    output logic        o_q_pop,
    input  logic        i_restart,
    input  logic [31:0] i_msg_len,
    input  logic [8:0]  i_entry_cnt,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    localparam int LIM   = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam int BUF_W = LIM + BYTE_BITS - 1;
    localparam int FW    = $clog2(BUF_W + 1);
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int IW    = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LRD, S_LEV, S_MRD, S_MEV, S_HIT, S_ERR, S_FIN
    } t_state;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_ent;

    t_state      r_state, n_state;
    logic [BUF_W-1:0] r_buf, n_buf;
    logic [FW-1:0]    r_fill, n_fill;
    logic [31:0] r_dec, n_dec;
    logic [5:0]  r_long, n_long;
    logic        r_stop, n_stop;
    logic [IW-1:0] r_idx, n_idx;
    logic [3:0]  r_nres, n_nres;
    logic [7:0]  r_hsym, n_hsym;
    logic [5:0]  r_hlen, n_hlen;
    logic        r_pv, n_pv;
    t_out_item   r_pend, n_pend;
    logic        r_ov, n_ov;
    t_out_item   r_od, n_od;

    logic          rd_en;
    logic          out_free;
    logic [IW-1:0] cnt;
    logic          usable;
    logic          fits;
    logic [FW-1:0] sh;
    logic [31:0]   cm;
    logic          match;
    logic [FW:0]   sum;
    logic [FW-1:0] nf;
    logic [31:0]   dec_inc;
    logic          ld_en;

    assign out_free    = !r_ov || i_out_ready;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;
    assign cnt = (i_entry_cnt > 9'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH) : IW'(i_entry_cnt);
    assign usable = (r_ent.length != 6'd0) && (r_ent.length <= 6'(LIM));
    assign fits   = (7'(r_ent.length) <= 7'(r_fill));
    assign sh     = r_fill - FW'(r_ent.length);
    assign cm     = r_ent.code & (32'hFFFF_FFFF >> (6'd32 - r_ent.length));
    assign match  = usable && fits && ((r_buf >> sh) == BUF_W'(cm[LIM-1:0]));
    assign sum    = (FW+1)'(r_fill) + (FW+1)'(BYTE_BITS);
    assign nf     = r_fill - FW'(r_hlen);
    assign dec_inc = r_dec + 32'd1;
    assign ld_en  = o_q_pop && (i_q_data.mode == MODE_LOAD)
                    && (9'(i_q_data.entry_index) < 9'(TABLE_DEPTH));

    always_comb begin
        n_state = r_state;
        n_buf   = r_buf;
        n_fill  = r_fill;
        n_dec   = r_dec;
        n_long  = r_long;
        n_stop  = r_stop;
        n_idx   = r_idx;
        n_nres  = r_nres;
        n_hsym  = r_hsym;
        n_hlen  = r_hlen;
        n_pv    = r_pv;
        n_pend  = r_pend;
        n_ov    = r_ov && !i_out_ready;
        n_od    = r_od;
        rd_en   = 1'b0;
        o_q_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_data.mode == MODE_DATA && !r_stop && r_dec != i_msg_len) begin
                        n_buf  = {r_buf[BUF_W-BYTE_BITS-1:0], i_q_data.data_byte}
                                 & ~({BUF_W{1'b1}} << sum);
                        n_fill = FW'(sum);
                        n_idx  = '0;
                        n_long = 6'd0;
                        n_nres = 4'd0;
                        n_state = S_LRD;
                    end
                end
            end
            S_LRD: begin
                if (r_idx == cnt) begin
                    n_idx   = '0;
                    n_state = S_MRD;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_LEV;
                end
            end
            S_LEV: begin
                if (usable && r_ent.length > r_long) begin
                    n_long = r_ent.length;
                end
                n_idx   = r_idx + IW'(1);
                n_state = S_LRD;
            end
            S_MRD: begin
                if (r_idx == cnt) begin
                    n_state = (7'(r_fill) >= 7'(r_long)) ? S_ERR : S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_MEV;
                end
            end
            S_MEV: begin
                if (match) begin
                    n_hsym  = r_ent.symbol;
                    n_hlen  = r_ent.length;
                    n_state = S_HIT;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_MRD;
                end
            end
            S_HIT: begin
                if (!r_pv || out_free) begin
                    if (r_pv) begin
                        n_ov = 1'b1;
                        n_od = '{symbol: r_pend.symbol, done_res: r_pend.done_res,
                                 error: r_pend.error, last: 1'b0};
                    end
                    n_pv   = 1'b1;
                    n_pend = '{symbol: r_hsym, done_res: (dec_inc == i_msg_len),
                               error: 1'b0, last: 1'b0};
                    n_fill = nf;
                    n_buf  = r_buf & ~({BUF_W{1'b1}} << nf);
                    n_dec  = dec_inc;
                    n_nres = r_nres + 4'd1;
                    n_idx  = '0;
                    if (dec_inc == i_msg_len || r_nres == 4'(MAX_RESULTS - 1)) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_MRD;
                    end
                end
            end
            S_ERR: begin
                if (!r_pv || out_free) begin
                    if (r_pv) begin
                        n_ov = 1'b1;
                        n_od = '{symbol: r_pend.symbol, done_res: r_pend.done_res,
                                 error: r_pend.error, last: 1'b0};
                    end
                    n_pv    = 1'b1;
                    n_pend  = '{symbol: 8'd0, done_res: 1'b0, error: 1'b1, last: 1'b0};
                    n_stop  = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_pv) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_ov = 1'b1;
                    n_od = '{symbol: r_pend.symbol, done_res: r_pend.done_res,
                             error: r_pend.error, last: 1'b1};
                    n_pv    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_restart) begin
            n_buf  = '0;
            n_fill = '0;
            n_dec  = 32'd0;
            n_stop = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_buf   <= '0;
            r_fill  <= '0;
            r_dec   <= 32'd0;
            r_long  <= 6'd0;
            r_stop  <= 1'b0;
            r_idx   <= '0;
            r_nres  <= 4'd0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_buf   <= n_buf;
            r_fill  <= n_fill;
            r_dec   <= n_dec;
            r_long  <= n_long;
            r_stop  <= n_stop;
            r_idx   <= n_idx;
            r_nres  <= n_nres;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
        r_hsym <= n_hsym;
        r_hlen <= n_hlen;
        r_pend <= n_pend;
        r_od   <= n_od;
    end

    always_ff @(posedge i_clk) begin
        if (ld_en) begin
            r_mem[i_q_data.entry_index[AW-1:0]] <= '{symbol: i_q_data.entry_symbol,
                                                     length: i_q_data.entry_length,
                                                     code:   i_q_data.entry_code};
        end
        if (rd_en) begin
            r_ent <= r_mem[r_idx[AW-1:0]];
        end
    end

endmodule

### rtl/core/htd_chk.sv
`include "assert_macros.svh"

module htd_chk
    import htd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result dropped or changed while stalled")
    `AST_SAME(a_err_zero, i_clk, i_rst_n, o_out_valid && o_out_data.error, o_out_data.symbol == 8'd0 && !o_out_data.done_res, "error result carries data")
    `AST_SAME(a_err_last, i_clk, i_rst_n, o_out_valid && o_out_data.error, o_out_data.last, "error result not last")
    `AST_SAME(a_done_last, i_clk, i_rst_n, o_out_valid && o_out_data.done_res, o_out_data.last, "message end not last")

endmodule

bind huffman_table_decoder htd_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### sim/huffman_table_decoder_test.sv
`timescale 1ns / 100ps

module huffman_table_decoder_test;
    import htd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    huffman_table_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder shadow state
    bit [7:0]  tbl_sym [256];
    bit [5:0]  tbl_len [256];
    bit [31:0] tbl_code [256];
    bit [31:0] msg_len;
    bit [8:0]  ent_cnt;
    bit [63:0] bits_held;
    int        bits_fill;
    bit [31:0] sym_count;
    bit        halted;

    t_out_item decoded_q [$];
    int        mismatches;
    int        sent_items;
    bit        calm;

    // current code book for message building
    bit [31:0] book_code [32];
    int        book_len [32];
    int        book_size;

    function automatic bit [63:0] low_bits(int n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function automatic int entries_in_use();
        return (ent_cnt > 9'd256) ? 256 : int'(ent_cnt);
    endfunction

    function automatic bit len_ok(bit [5:0] l);
        return l >= 6'd1 && l <= 6'd32;
    endfunction

    function automatic void decode_item(t_in_item it);
        t_out_item res [8];
        int        n, longest, cnt, l;
        bit        hit;
        n = 0;
        if (it.mode == MODE_LOAD) begin
            tbl_sym[it.entry_index] = it.entry_symbol;
            tbl_len[it.entry_index] = it.entry_length;
            tbl_code[it.entry_index] = it.entry_code;
            return;
        end
        if (halted || sym_count == msg_len) return;
        cnt = entries_in_use();
        longest = 0;
        for (int i = 0; i < cnt; i++)
            if (len_ok(tbl_len[i]) && tbl_len[i] > longest) longest = tbl_len[i];
        bits_held = ((bits_held << 8) | 64'(it.data_byte)) & low_bits(bits_fill + 8);
        bits_fill += 8;
        while (n < MAX_RESULTS) begin
            hit = 1'b0;
            for (int i = 0; i < cnt; i++) begin
                l = tbl_len[i];
                if (!len_ok(tbl_len[i]) || l > bits_fill) continue;
                if ((bits_held >> (bits_fill - l)) == (64'(tbl_code[i]) & low_bits(l))) begin
                    bits_fill -= l;
                    bits_held &= low_bits(bits_fill);
                    sym_count++;
                    res[n] = '{symbol: tbl_sym[i], done_res: sym_count == msg_len,
                               error: 1'b0, last: 1'b0};
                    n++;
                    hit = 1'b1;
                    break;
                end
            end
            if (hit) begin
                if (sym_count == msg_len) break;
                continue;
            end
            if (bits_fill >= longest) begin
                res[n] = '{symbol: 8'd0, done_res: 1'b0, error: 1'b1, last: 1'b0};
                n++;
                halted = 1'b1;
            end
            break;
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) decoded_q.push_back(res[k]);
    endfunction

    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 11);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result, got %p", $time, o_out_data);
                mismatches++;
            end else begin
                want = decoded_q.pop_front();
                if (o_out_data.symbol !== want.symbol) begin
                    $display("%0t: symbol expected %h actual %h", $time, want.symbol,
                             o_out_data.symbol);
                    mismatches++;
                end
                if (o_out_data.done_res !== want.done_res) begin
                    $display("%0t: done_res expected %b actual %b", $time, want.done_res,
                             o_out_data.done_res);
                    mismatches++;
                end
                if (o_out_data.error !== want.error) begin
                    $display("%0t: error expected %b actual %b", $time, want.error,
                             o_out_data.error);
                    mismatches++;
                end
                if (o_out_data.last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last,
                             o_out_data.last);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_request(t_in_item it);
        int gap;
        if (!calm && $urandom_range(99) < 11) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        decode_item(it);
        sent_items++;
    endtask

    task automatic load_entry(int idx, bit [7:0] sym, bit [5:0] len, bit [31:0] code);
        t_in_item it;
        it = '0;
        it.mode = MODE_LOAD;
        it.entry_index = 8'(idx);
        it.entry_symbol = sym;
        it.entry_length = len;
        it.entry_code = code;
        it.data_byte = 8'($urandom);
        send_request(it);
    endtask

    task automatic send_byte(bit [7:0] b);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, $urandom});
        it.mode = MODE_DATA;
        it.data_byte = b;
        send_request(it);
    endtask

    // wait for outstanding results, then for any byte still being scanned
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (3 * (10 + 18 * entries_in_use())) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, bit [31:0] value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(4 * int'(idx));
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_MSG_LEN) begin
            msg_len = value;
            bits_held = '0;
            bits_fill = 0;
            sym_count = '0;
            halted = 1'b0;
        end else begin
            ent_cnt = value[8:0];
        end
    endtask

    // random prefix code by splitting leaves; optionally drops one leaf
    task automatic make_book(int k, int max_len, bit complete);
        int pick, tries;
        book_code[0] = 0; book_len[0] = 1;
        book_code[1] = 1; book_len[1] = 1;
        book_size = 2;
        tries = 0;
        while (book_size < k && tries < 200) begin
            tries++;
            pick = $urandom_range(book_size - 1);
            if (book_len[pick] >= max_len) continue;
            book_code[book_size] = (book_code[pick] << 1) | 32'd1;
            book_len[book_size] = book_len[pick] + 1;
            book_code[pick] = book_code[pick] << 1;
            book_len[pick]++;
            book_size++;
        end
        if (!complete && book_size > 2) book_size--;
    endtask

    task automatic load_book(int base);
        bit [31:0] junk;
        for (int i = 0; i < book_size; i++) begin
            junk = $urandom;
            if (book_len[i] < 32) junk = (junk << book_len[i]) | book_code[i];
            else junk = book_code[i];
            load_entry(base + i, 8'($urandom), 6'(book_len[i]), junk);
        end
    endtask

    // encodes random symbols from the book and streams them as bytes
    task automatic send_message(int nsym);
        bit q [$];
        bit [7:0] b;
        int s;
        for (int i = 0; i < nsym; i++) begin
            s = $urandom_range(book_size - 1);
            for (int j = book_len[s] - 1; j >= 0; j--) q.push_back(book_code[s][j]);
        end
        while (q.size() % 8 != 0) q.push_back(1'($urandom));
        while (q.size() != 0) begin
            for (int j = 7; j >= 0; j--) b[j] = q.pop_front();
            send_byte(b);
        end
    endtask

    task automatic test_zero_length();
        load_entry(0, 8'hA5, 6'd1, 32'hFFFF_FFFF);
        send_byte(8'h00);
        write_reg(REG_MSG_LEN, 32'd0);
        send_byte(8'hFF);
    endtask

    task automatic test_done_and_burst();
        load_entry(0, 8'h5A, 6'd1, 32'hFFFF_FFFE);
        write_reg(REG_ENTRY_CNT, 9'd1);
        write_reg(REG_MSG_LEN, 32'd5);
        send_byte(8'h00);
        send_byte(8'h00);
        write_reg(REG_MSG_LEN, 32'hFFFF_FFFF);
        send_byte(8'h00);
        send_byte(8'h0F);
    endtask

    task automatic test_unusable();
        load_entry(0, 8'h11, 6'd0, 32'd0);
        write_reg(REG_MSG_LEN, 32'd3);
        send_byte(8'h00);
        send_byte(8'h00);
        load_entry(0, 8'h22, 6'd63, 32'd0);
        write_reg(REG_MSG_LEN, 32'd3);
        send_byte(8'hAA);
        load_entry(0, 8'h33, 6'd33, 32'd0);
        write_reg(REG_MSG_LEN, 32'd3);
        send_byte(8'h55);
    endtask

    task automatic test_long_code();
        load_entry(0, 8'hFE, 6'd32, 32'hFFFF_FFFF);
        load_entry(1, 8'h01, 6'd1, 32'h0000_0000);
        write_reg(REG_ENTRY_CNT, 9'd2);
        write_reg(REG_MSG_LEN, 32'd20);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(8'h81);
    endtask

    task automatic test_random_tables();
        int k, max_len, nmsg;
        int round;
        round = 0;
        while (sent_items < 130) begin
            calm = (round == 3);
            k = $urandom_range(2, 16);
            case ($urandom_range(3))
                0: max_len = 4;
                1: max_len = 8;
                2: max_len = 12;
                default: max_len = 32;
            endcase
            make_book(k, max_len, $urandom_range(99) < 80);
            load_book(0);
            write_reg(REG_ENTRY_CNT, 9'(book_size));
            nmsg = $urandom_range(1, 3);
            for (int m = 0; m < nmsg; m++) begin
                k = $urandom_range(1, 24);
                write_reg(REG_MSG_LEN, 32'(k + $urandom_range(0, 1)));
                if ($urandom_range(99) < 15) begin
                    repeat ($urandom_range(1, 6)) begin
                        send_byte(8'($urandom));
                    end
                end else begin
                    send_message(k);
                end
            end
            round++;
        end
        calm = 1'b0;
    endtask

    task automatic test_wide_table();
        int base;
        base = 24;
        for (int i = 0; i < base; i++) begin
            if (i % 3 == 0) load_entry(i, 8'($urandom), 6'd0, $urandom);
            else load_entry(i, 8'($urandom), 6'($urandom_range(33, 63)), $urandom);
        end
        make_book(8, 5, 1'b1);
        load_book(base);
        write_reg(REG_ENTRY_CNT, 9'(base + book_size));
        write_reg(REG_MSG_LEN, 32'd6);
        send_message(6);
        write_reg(REG_ENTRY_CNT, 9'd1);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_out_ready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        mismatches = 0;
        sent_items = 0;
        calm = 1'b0;
        msg_len = '0;
        ent_cnt = 9'd1;
        bits_held = '0;
        bits_fill = 0;
        sym_count = '0;
        halted = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_length();
        test_done_and_burst();
        test_unusable();
        test_long_code();
        test_random_tables();
        test_wide_table();
        drain();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
